[rtl/ipgm_pkg.sv]
// Shared constants, types and saturation helpers for the ground map pipeline.
package ipgm_pkg;

   localparam int SCREEN_BITS     = 12;
   localparam int WORLD_FRAC_BITS = 16;
   localparam int COEF_FRAC_BITS  = 32;
   localparam int COEF_W          = 48;
   localparam int WORLD_W         = 32;
   localparam int SCREEN_OUT_W    = 16;
   localparam int CFG_W           = SCREEN_BITS + 1;
   localparam int CENTER_W        = SCREEN_BITS + 1;
   localparam int CSR_INDEX_W     = 8;
   localparam int SUM_W           = 81;
   localparam int MAG_W           = SUM_W - 1;
   localparam int QUOT_W          = 32;
   localparam int DIV_LAT         = QUOT_W + 1;
   localparam int QS_W            = 22;
   localparam int SCR_SUM_W       = QS_W + 1;

   localparam logic [QUOT_W:0] LIM_WORLD  = (QUOT_W + 1)'((64'd1 << (WORLD_W - 1)) - 64'd1);
   localparam logic [QUOT_W:0] LIM_SCREEN = (QUOT_W + 1)'((64'd1 << (QS_W - 2)) - 64'd1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT,
      REG_COEF_ONE,
      REG_COEF_TWO,
      REG_COEF_THREE,
      REG_COEF_FOUR,
      REG_COEF_FIVE
   } csr_index_type;

   typedef enum logic {
      CMD_TO_WORLD,
      CMD_TO_SCREEN
   } command_type;

   typedef struct packed {
      command_type                 cmd;
      logic                        fault;
      logic                        qneg1;
      logic                        qneg2;
      logic signed [CENTER_W-1:0]  cx;
   } div_side_type;

   // Clamps a truncated quotient magnitude to a signed range and applies its sign.
   function automatic logic signed [QUOT_W:0] sat_quot(input logic over,
                                                       input logic [QUOT_W-1:0] quot,
                                                       input logic neg,
                                                       input logic [QUOT_W:0] lim_pos);
      logic [QUOT_W:0] lim;
      logic [QUOT_W:0] mag;
      lim = lim_pos + (QUOT_W + 1)'(neg);
      mag = (over || ({1'b0, quot} > lim)) ? lim : {1'b0, quot};
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic [SCREEN_OUT_W-1:0] sat16(input logic signed [SCR_SUM_W-1:0] v);
      logic [SCREEN_OUT_W-1:0] r;
      if (v > 23'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -23'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[SCREEN_OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

[rtl/ipgm_req_if.sv]
// Request channel carrying one point to be mapped.
interface ipgm_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  command;
   logic        [ipgm_pkg::SCREEN_BITS-1:0] screen_col;
   logic        [ipgm_pkg::SCREEN_BITS-1:0] screen_row;
   logic signed [ipgm_pkg::WORLD_W-1:0]     ground_x;
   logic signed [ipgm_pkg::WORLD_W-1:0]     ground_y;

   modport source(output valid, command, screen_col, screen_row, ground_x, ground_y,
                  input ready);
   modport sink(input valid, command, screen_col, screen_row, ground_x, ground_y,
                output ready);
endinterface

[rtl/ipgm_rsp_if.sv]
// Result channel carrying one mapped point.
interface ipgm_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [ipgm_pkg::WORLD_W-1:0]      out_ground_x;
   logic signed [ipgm_pkg::WORLD_W-1:0]      out_ground_y;
   logic signed [ipgm_pkg::SCREEN_OUT_W-1:0] out_screen_col;
   logic signed [ipgm_pkg::SCREEN_OUT_W-1:0] out_screen_row;
   logic                                    divide_fault;

   modport source(output valid, out_ground_x, out_ground_y, out_screen_col, out_screen_row,
                  divide_fault, input ready);
   modport sink(input valid, out_ground_x, out_ground_y, out_screen_col, out_screen_row,
                divide_fault, output ready);
endinterface

[rtl/ipgm_div.sv]
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module ipgm_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [ipgm_pkg::MAG_W-1:0]   num_mag,
   input  logic [ipgm_pkg::MAG_W-1:0]   den_mag,
   output logic [ipgm_pkg::QUOT_W-1:0]  quot,
   output logic                         over
);
   import ipgm_pkg::*;

   localparam int WIDE_W = MAG_W + QUOT_W;

   logic [MAG_W-1:0]  rem_ff  [QUOT_W];
   logic [MAG_W-1:0]  den_ff  [QUOT_W];
   logic [QUOT_W-1:0] quot_ff [DIV_LAT];
   logic              over_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= num_mag;
         den_ff[0]  <= den_mag;
         quot_ff[0] <= '0;
         over_ff[0] <= {QUOT_W'(0), num_mag} >= {den_mag, QUOT_W'(0)};
      end
   end

   for (genvar s = 0; s < QUOT_W; s++) begin : g_step
      localparam int BIT = QUOT_W - 1 - s;
      logic [WIDE_W:0] trial;

      assign trial = {1'b0, WIDE_W'(rem_ff[s])} - {1'b0, WIDE_W'(den_ff[s]) << BIT};

      always_ff @(posedge clock) begin
         if (en) begin
            quot_ff[s+1] <= quot_ff[s] | (QUOT_W'(!trial[WIDE_W]) << BIT);
            over_ff[s+1] <= over_ff[s];
         end
      end

      if (s < QUOT_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s+1] <= trial[WIDE_W] ? rem_ff[s] : trial[MAG_W-1:0];
               den_ff[s+1] <= den_ff[s];
            end
         end
      end
   end

   assign quot = quot_ff[QUOT_W];
   assign over = over_ff[QUOT_W];

endmodule

[rtl/inverse_perspective_ground_map.sv]
// Flat ground mapping between camera pixels and world points: one request per cycle while
// the result is not stalled, passing through four setup stages, a 33 stage divider pair and
// five finishing stages; the divider pair is the deepest part, and a stalled result
// holds the whole pipeline.
module inverse_perspective_ground_map (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [ipgm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ipgm_pkg::COEF_W-1:0]        csr_wdata,
   ipgm_req_if.sink                           req_chan,
   ipgm_rsp_if.source                         rsp_chan
);
   import ipgm_pkg::*;

   localparam int PA_W   = COEF_W + CENTER_W;
   localparam int PB_W   = COEF_W + WORLD_W;
   localparam int PROD_W = SUM_W + CENTER_W;
   localparam int GX_W   = PROD_W - COEF_FRAC_BITS;
   localparam logic signed [PROD_W-1:0] TRUNC_BIAS =
      (PROD_W'(1) << COEF_FRAC_BITS) - PROD_W'(1);

   logic [CFG_W-1:0]         image_width_ff, image_height_ff;
   logic signed [COEF_W-1:0] k1_ff, k2_ff, k3_ff, k4_ff, k5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= CFG_W'(640);
         image_height_ff <= CFG_W'(480);
         k1_ff <= '0;
         k2_ff <= '0;
         k3_ff <= '0;
         k4_ff <= '0;
         k5_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[CFG_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[CFG_W-1:0];
            end
            REG_COEF_ONE: begin
               k1_ff <= csr_wdata;
            end
            REG_COEF_TWO: begin
               k2_ff <= csr_wdata;
            end
            REG_COEF_THREE: begin
               k3_ff <= csr_wdata;
            end
            REG_COEF_FOUR: begin
               k4_ff <= csr_wdata;
            end
            REG_COEF_FIVE: begin
               k5_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   logic [SCREEN_BITS-1:0] half_w, half_h;
   assign half_w = image_width_ff[CFG_W-1:1];
   assign half_h = image_height_ff[CFG_W-1:1];

   logic rsp_valid_ff;
   logic en;
   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // Stage 1: center the pixel.
   logic                       v1_ff;
   command_type                cmd1_ff;
   logic signed [CENTER_W-1:0] cy1_ff, cx1_ff, cy_in, cx_in;
   logic signed [WORLD_W-1:0]  wx1_ff, wy1_ff;

   assign cy_in = $signed({1'b0, half_h}) - $signed({1'b0, req_chan.screen_row});
   assign cx_in = $signed({1'b0, req_chan.screen_col}) - $signed({1'b0, half_w});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmd1_ff <= command_type'(req_chan.command);
         cy1_ff  <= cy_in;
         cx1_ff  <= cx_in;
         wx1_ff  <= req_chan.ground_x;
         wy1_ff  <= req_chan.ground_y;
      end
   end

   // Stage 2: coefficient products.
   logic                       v2_ff;
   command_type                cmd2_ff;
   logic signed [CENTER_W-1:0] cy2_ff, cx2_ff;
   logic signed [WORLD_W-1:0]  wx2_ff, wy2_ff;
   logic signed [PA_W-1:0]     pa_in, pa2_ff;
   logic signed [PB_W-1:0]     pb_in, pc_in, pb2_ff, pc2_ff;

   assign pa_in = k2_ff * cy1_ff;
   assign pb_in = k5_ff * wy1_ff;
   assign pc_in = k3_ff * wy1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmd2_ff <= cmd1_ff;
         cy2_ff  <= cy1_ff;
         cx2_ff  <= cx1_ff;
         wx2_ff  <= wx1_ff;
         wy2_ff  <= wy1_ff;
         pa2_ff  <= pa_in;
         pb2_ff  <= pb_in;
         pc2_ff  <= pc_in;
      end
   end

   // Stage 3: numerators, denominators and the zero divisor check.
   logic                       v3_ff, fault3_ff, fault_in;
   command_type                cmd3_ff;
   logic signed [CENTER_W-1:0] cx3_ff;
   logic signed [SUM_W-1:0]    num_s, den_s, dx_s, dy_s, nx_s, ny_s;
   logic signed [SUM_W-1:0]    n1_in, d1_in, n1_3_ff, d1_3_ff, n2_3_ff, d2_3_ff;

   assign num_s = SUM_W'(k1_ff) + SUM_W'(pa2_ff);
   assign den_s = SUM_W'(k3_ff) - (SUM_W'(cy2_ff) <<< COEF_FRAC_BITS);
   assign dx_s  = (SUM_W'(k4_ff) <<< WORLD_FRAC_BITS) + SUM_W'(pb2_ff);
   assign dy_s  = (SUM_W'(k2_ff) <<< WORLD_FRAC_BITS) + (SUM_W'(wy2_ff) <<< COEF_FRAC_BITS);
   assign nx_s  = SUM_W'(wx2_ff) <<< COEF_FRAC_BITS;
   assign ny_s  = SUM_W'(pc2_ff) - (SUM_W'(k1_ff) <<< WORLD_FRAC_BITS);

   assign n1_in    = (cmd2_ff == CMD_TO_SCREEN) ? nx_s : (num_s <<< WORLD_FRAC_BITS);
   assign d1_in    = (cmd2_ff == CMD_TO_SCREEN) ? dx_s : den_s;
   assign fault_in = (cmd2_ff == CMD_TO_SCREEN) ? ((dx_s == '0) || (dy_s == '0))
                                                : (den_s == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmd3_ff   <= cmd2_ff;
         cx3_ff    <= cx2_ff;
         fault3_ff <= fault_in;
         n1_3_ff   <= n1_in;
         d1_3_ff   <= d1_in;
         n2_3_ff   <= ny_s;
         d2_3_ff   <= dy_s;
      end
   end

   // Stage 4: magnitudes and quotient signs.
   logic               v4_ff;
   div_side_type       side4_ff;
   logic [MAG_W-1:0]   n1m_ff, d1m_ff, n2m_ff, d2m_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side4_ff.cmd   <= cmd3_ff;
         side4_ff.fault <= fault3_ff;
         side4_ff.qneg1 <= n1_3_ff[SUM_W-1] ^ d1_3_ff[SUM_W-1];
         side4_ff.qneg2 <= n2_3_ff[SUM_W-1] ^ d2_3_ff[SUM_W-1];
         side4_ff.cx    <= cx3_ff;
         n1m_ff <= MAG_W'(n1_3_ff[SUM_W-1] ? -n1_3_ff : n1_3_ff);
         d1m_ff <= MAG_W'(d1_3_ff[SUM_W-1] ? -d1_3_ff : d1_3_ff);
         n2m_ff <= MAG_W'(n2_3_ff[SUM_W-1] ? -n2_3_ff : n2_3_ff);
         d2m_ff <= MAG_W'(d2_3_ff[SUM_W-1] ? -d2_3_ff : d2_3_ff);
      end
   end

   // Divider pair with side data kept in step.
   logic [QUOT_W-1:0] q1, q2;
   logic              ovf1, ovf2;

   ipgm_div u_div_one (
      .clock   (clock),
      .en      (en),
      .num_mag (n1m_ff),
      .den_mag (d1m_ff),
      .quot    (q1),
      .over    (ovf1)
   );

   ipgm_div u_div_two (
      .clock   (clock),
      .en      (en),
      .num_mag (n2m_ff),
      .den_mag (d2m_ff),
      .quot    (q2),
      .over    (ovf2)
   );

   logic         dv_ff   [DIV_LAT];
   div_side_type side_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            dv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         dv_ff[0] <= v4_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            dv_ff[i] <= dv_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side4_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Stage 5: saturate the quotients.
   logic                       v5_ff;
   div_side_type               side5_ff;
   logic signed [QUOT_W:0]     gy_sat, qx_sat, qy_sat;
   logic signed [WORLD_W-1:0]  gy5_ff;
   logic signed [QS_W-1:0]     qx5_ff, qy5_ff;

   assign gy_sat = sat_quot(ovf1, q1, side_ff[DIV_LAT-1].qneg1, LIM_WORLD);
   assign qx_sat = sat_quot(ovf1, q1, side_ff[DIV_LAT-1].qneg1, LIM_SCREEN);
   assign qy_sat = sat_quot(ovf2, q2, side_ff[DIV_LAT-1].qneg2, LIM_SCREEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= dv_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side5_ff <= side_ff[DIV_LAT-1];
         gy5_ff   <= gy_sat[WORLD_W-1:0];
         qx5_ff   <= qx_sat[QS_W-1:0];
         qy5_ff   <= qy_sat[QS_W-1:0];
      end
   end

   // Stage 6: lateral slope product and screen origin.
   logic                           v6_ff;
   div_side_type                   side6_ff;
   logic signed [PB_W-1:0]         pe_in, pe6_ff;
   logic signed [WORLD_W-1:0]      gy6_ff;
   logic [SCREEN_OUT_W-1:0]        scol6_ff, srow6_ff;

   assign pe_in = k5_ff * gy5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side6_ff <= side5_ff;
         pe6_ff   <= pe_in;
         gy6_ff   <= gy5_ff;
         scol6_ff <= sat16(SCR_SUM_W'(qx5_ff) + SCR_SUM_W'($signed({1'b0, half_w})));
         srow6_ff <= sat16(SCR_SUM_W'($signed({1'b0, half_h})) - SCR_SUM_W'(qy5_ff));
      end
   end

   // Stage 7: lateral scale.
   logic                       v7_ff;
   div_side_type               side7_ff;
   logic signed [SUM_W-1:0]    scale7_ff;
   logic signed [WORLD_W-1:0]  gy7_ff;
   logic [SCREEN_OUT_W-1:0]    scol7_ff, srow7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side7_ff  <= side6_ff;
         scale7_ff <= (SUM_W'(k4_ff) <<< WORLD_FRAC_BITS) + SUM_W'(pe6_ff);
         gy7_ff    <= gy6_ff;
         scol7_ff  <= scol6_ff;
         srow7_ff  <= srow6_ff;
      end
   end

   // Stage 8: scale times centered column.
   logic                       v8_ff;
   div_side_type               side8_ff;
   logic signed [PROD_W-1:0]   prod_in, prod8_ff;
   logic signed [WORLD_W-1:0]  gy8_ff;
   logic [SCREEN_OUT_W-1:0]    scol8_ff, srow8_ff;

   assign prod_in = scale7_ff * side7_ff.cx;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side8_ff <= side7_ff;
         prod8_ff <= prod_in;
         gy8_ff   <= gy7_ff;
         scol8_ff <= scol7_ff;
         srow8_ff <= srow7_ff;
      end
   end

   // Stage 9: rescale, saturate and select the result fields.
   logic signed [GX_W-1:0]    gx_q;
   logic signed [WORLD_W-1:0] gx_sat;
   logic                      world_ok, screen_ok;

   assign gx_q = GX_W'((prod8_ff[PROD_W-1] ? prod8_ff + TRUNC_BIAS : prod8_ff)
                       >>> COEF_FRAC_BITS);
   assign gx_sat = (gx_q > 62'sd2147483647)  ? 32'sh7FFFFFFF :
                   (gx_q < -62'sd2147483648) ? 32'sh80000000 : gx_q[WORLD_W-1:0];
   assign world_ok  = (side8_ff.cmd == CMD_TO_WORLD) && !side8_ff.fault;
   assign screen_ok = (side8_ff.cmd == CMD_TO_SCREEN) && !side8_ff.fault;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_chan.out_ground_x   <= world_ok ? gx_sat : '0;
         rsp_chan.out_ground_y   <= world_ok ? gy8_ff : '0;
         rsp_chan.out_screen_col <= screen_ok ? scol8_ff : '0;
         rsp_chan.out_screen_row <= screen_ok ? srow8_ff : '0;
         rsp_chan.divide_fault   <= side8_ff.fault;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

endmodule

[rtl/ipgm_checker.sv]
// Port-level checks on the ground map results, bound to the top level.
module ipgm_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic signed [ipgm_pkg::WORLD_W-1:0]      out_ground_x,
   input logic signed [ipgm_pkg::WORLD_W-1:0]      out_ground_y,
   input logic signed [ipgm_pkg::SCREEN_OUT_W-1:0] out_screen_col,
   input logic signed [ipgm_pkg::SCREEN_OUT_W-1:0] out_screen_row,
   input logic                                     divide_fault
);
   import ipgm_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_ground_x) &&
      $stable(out_ground_y) && $stable(out_screen_col) && $stable(out_screen_row))
      else $error("A stalled result changed.");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && divide_fault |-> out_ground_x == '0 && out_ground_y == '0 &&
      out_screen_col == '0 && out_screen_row == '0)
      else $error("A faulted result carries nonzero fields.");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (out_screen_col != '0 || out_screen_row != '0) |->
      out_ground_x == '0 && out_ground_y == '0)
      else $error("A result carries both screen and world fields.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("A result is shown right after reset.");

endmodule

bind inverse_perspective_ground_map ipgm_checker u_ipgm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .out_ground_x   (rsp_chan.out_ground_x),
   .out_ground_y   (rsp_chan.out_ground_y),
   .out_screen_col (rsp_chan.out_screen_col),
   .out_screen_row (rsp_chan.out_screen_row),
   .divide_fault   (rsp_chan.divide_fault)
);
